>>> rtl/convex_polygon_pixel_shader_top_defines.svh
// assertion macros for the convex polygon pixel shader
// used by the controller and datapath modules, no other dependencies
`ifndef CONVEX_POLYGON_PIXEL_SHADER_TOP_DEFINES_SVH
`define CONVEX_POLYGON_PIXEL_SHADER_TOP_DEFINES_SVH

// same-cycle implication
`define CPPS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpps assertion failed");

// next-cycle implication
`define CPPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cpps assertion failed");

`endif

>>> rtl/cpps_pkg.sv
// shared types and constants for the convex polygon pixel shader
// no dependencies
package cpps_pkg;

   localparam int MAX_VERTICES_DEF   = 32;
   localparam int FRACTION_BITS_DEF  = 6;
   localparam int MAX_IMAGE_SIZE     = 1024;

   localparam int COORD_W = 16;
   localparam int PIXEL_W = 10;
   localparam int OWIDTH_W = 4;
   localparam int HEIGHT_W = 11;
   localparam int CSR_DATA_W = 11;

   localparam logic [OWIDTH_W-1:0] OWIDTH_RESET = 4'd2;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 11'd1000;

   localparam logic CSR_IDX_OWIDTH = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      FUNC_START  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_QUERY  = 2'd2
   } func_type;

   localparam logic [1:0] COLOUR_NONE  = 2'd0;
   localparam logic [1:0] COLOUR_BLUE  = 2'd1;
   localparam logic [1:0] COLOUR_BLACK = 2'd2;

   typedef struct packed {
      logic start_poly;
      logic append;
      logic query_start;
      logic rd_issue;
      logic load_simple;
      logic load_query;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic rd_last;
      logic done;
   } sts_type;

endpackage

>>> rtl/cpps_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module cpps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/cpps_ctrl.sv
// controller state machine for the convex polygon pixel shader
// depends on cpps_pkg and the assertion macro header
`include "convex_polygon_pixel_shader_top_defines.svh"

module cpps_ctrl
   import cpps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_func,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output cmd_type    cmd,
   input  sts_type    sts
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_START: begin
                     cmd.start_poly  = 1'b1;
                     cmd.load_simple = 1'b1;
                     rsp_valid_in    = 1'b1;
                  end
                  FUNC_APPEND: begin
                     cmd.append      = 1'b1;
                     cmd.load_simple = 1'b1;
                     rsp_valid_in    = 1'b1;
                  end
                  FUNC_QUERY: begin
                     cmd.query_start = 1'b1;
                     state_in        = sts.empty ? ST_FIN : ST_RUN;
                  end
                  default: begin
                     cmd.load_simple = 1'b1;
                     rsp_valid_in    = 1'b1;
                  end
               endcase
            end
         end
         ST_RUN: begin
            cmd.rd_issue = 1'b1;
            if (sts.rd_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (sts.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.load_query = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CPPS_ASSERT_NOW(a_accept_idle, clock, reset, req_tvalid && req_tready, state_ff == ST_IDLE)
   `CPPS_ASSERT_NOW(a_one_load, clock, reset, cmd.load_query, !cmd.load_simple && !cmd.rd_issue)
   `CPPS_ASSERT_NEXT(a_run_next, clock, reset, state_ff == ST_RUN,
                     state_ff == ST_RUN || state_ff == ST_WAIT)
   `CPPS_ASSERT_NEXT(a_empty_query, clock, reset,
                     accept && req_func == FUNC_QUERY && sts.empty, state_ff == ST_FIN)

endmodule

>>> rtl/cpps_dp.sv
// datapath: vertex store, edge-function pipeline, accumulators, result register
// depends on cpps_pkg, cpps_ram and the assertion macro header
`include "convex_polygon_pixel_shader_top_defines.svh"

module cpps_dp
   import cpps_pkg::*;
#(
   parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  in_fluid,
   input  logic [COORD_W-1:0]    in_vx,
   input  logic [COORD_W-1:0]    in_vy,
   input  logic [PIXEL_W-1:0]    in_px,
   input  logic [PIXEL_W-1:0]    in_py,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic [1:0]            out_colour,
   output logic [PIXEL_W-1:0]    out_column,
   output logic [PIXEL_W-1:0]    out_row,
   output logic                  out_status
);

   localparam int IW   = $clog2(MAX_VERTICES);
   localparam int CNTW = $clog2(MAX_VERTICES + 1);
   localparam int SXW  = PIXEL_W + FRACTION_BITS;
   localparam int DW   = ((SXW > COORD_W) ? SXW : COORD_W) + 1;
   localparam int PW   = 2 * DW;
   localparam int RBW  = PW + 2 * OWIDTH_W;
   localparam int LW0  = 4 * DW;
   localparam int RW0  = RBW + 2 * FRACTION_BITS;
   localparam int CMPW = (LW0 > RW0) ? LW0 : RW0;
   localparam int VW   = 2 * COORD_W;

   // configuration
   logic [OWIDTH_W-1:0] owidth_ff;
   logic [HEIGHT_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         owidth_ff <= OWIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IDX_OWIDTH: owidth_ff <= csr_wdata[OWIDTH_W-1:0];
            CSR_IDX_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // polygon state
   logic [CNTW-1:0] count_ff;
   logic            fluid_ff;
   logic            full;

   assign full = (count_ff == CNTW'(MAX_VERTICES));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fluid_ff <= 1'b0;
      end else if (cmd.start_poly) begin
         count_ff <= '0;
         fluid_ff <= in_fluid;
      end else if (cmd.append && !full) begin
         count_ff <= count_ff + CNTW'(1);
      end
   end

   // vertex store
   logic [IW-1:0] rd_idx_ff;
   logic [VW-1:0] rd_data;

   cpps_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_store (
      .clock (clock),
      .we    (cmd.append && !full),
      .waddr (count_ff[IW-1:0]),
      .wdata ({in_vy, in_vx}),
      .raddr (rd_idx_ff),
      .rdata (rd_data)
   );

   // read sequencing
   logic rd_last;
   logic rv_ff, rfirst_ff, rlast_ff, close_ff;

   assign rd_last = (CNTW'(rd_idx_ff) == count_ff - CNTW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         rv_ff     <= 1'b0;
         close_ff  <= 1'b0;
      end else begin
         if (cmd.query_start) begin
            rd_idx_ff <= '0;
         end else if (cmd.rd_issue) begin
            rd_idx_ff <= rd_idx_ff + IW'(1);
         end
         rv_ff    <= cmd.rd_issue;
         close_ff <= rv_ff && rlast_ff;
      end
      rfirst_ff <= (rd_idx_ff == '0);
      rlast_ff  <= rd_last;
   end

   // query pixel
   logic [PIXEL_W-1:0] px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         px_ff <= in_px;
         py_ff <= in_py;
      end
   end

   // edge forming
   logic [VW-1:0] v0_ff, prev_ff;
   logic [VW-1:0] ea, eb;
   logic          e_vld, e_lst;

   always_ff @(posedge clock) begin
      if (rv_ff) begin
         prev_ff <= rd_data;
         if (rfirst_ff) begin
            v0_ff <= rd_data;
         end
      end
   end

   always_comb begin
      ea    = prev_ff;
      eb    = close_ff ? v0_ff : rd_data;
      e_vld = close_ff || (rv_ff && !rfirst_ff);
      e_lst = close_ff;
   end

   // stage a: differences
   logic signed [DW-1:0] sx, sy;
   logic signed [DW-1:0] ex_ff, ey_ff, dx_ff, dy_ff;
   logic                 a_vld_ff, a_lst_ff;

   assign sx = $signed(DW'(px_ff) << FRACTION_BITS);
   assign sy = $signed(DW'(py_ff) << FRACTION_BITS);

   always_ff @(posedge clock) begin
      ex_ff <= $signed(DW'(eb[COORD_W-1:0])) - $signed(DW'(ea[COORD_W-1:0]));
      ey_ff <= $signed(DW'(eb[VW-1:COORD_W])) - $signed(DW'(ea[VW-1:COORD_W]));
      dx_ff <= sx - $signed(DW'(ea[COORD_W-1:0]));
      dy_ff <= sy - $signed(DW'(ea[VW-1:COORD_W]));
   end

   // stage b: products
   logic signed [PW-1:0] p_dxey_ff, p_dyex_ff, p_exex_ff, p_eyey_ff, p_dxex_ff, p_dyey_ff;
   logic                 b_vld_ff, b_lst_ff;

   always_ff @(posedge clock) begin
      p_dxey_ff <= dx_ff * ey_ff;
      p_dyex_ff <= dy_ff * ex_ff;
      p_exex_ff <= ex_ff * ex_ff;
      p_eyey_ff <= ey_ff * ey_ff;
      p_dxex_ff <= dx_ff * ex_ff;
      p_dyey_ff <= dy_ff * ey_ff;
   end

   // stage c: determinant, squared length, projection
   logic signed [PW:0] det_ff, len2_ff, dot_ff;
   logic               c_vld_ff, c_lst_ff;

   always_ff @(posedge clock) begin
      det_ff  <= (PW+1)'(p_dxey_ff) - (PW+1)'(p_dyex_ff);
      len2_ff <= (PW+1)'(p_exex_ff) + (PW+1)'(p_eyey_ff);
      dot_ff  <= (PW+1)'(p_dxex_ff) + (PW+1)'(p_dyey_ff);
   end

   // stage d: sign, partial squares of |det|, width times length
   logic [PW:0]             ad_full;
   logic [PW-1:0]           ad;
   logic [2*OWIDTH_W-1:0]   w2;
   logic [PW-1:0]           pp_hh_ff, pp_hl_ff, pp_ll_ff;
   logic [RBW-1:0]          rb_ff;
   logic                    pos_ff, neg_ff, span_ff;
   logic                    d_vld_ff, d_lst_ff;

   assign ad_full = det_ff[PW] ? (PW+1)'(-det_ff) : (PW+1)'(det_ff);
   assign ad      = ad_full[PW-1:0];
   assign w2      = owidth_ff * owidth_ff;

   always_ff @(posedge clock) begin
      pp_hh_ff <= ad[PW-1:DW] * ad[PW-1:DW];
      pp_hl_ff <= ad[PW-1:DW] * ad[DW-1:0];
      pp_ll_ff <= ad[DW-1:0] * ad[DW-1:0];
      rb_ff    <= RBW'(w2) * RBW'(len2_ff[PW-1:0]);
      pos_ff   <= !det_ff[PW] && (det_ff != '0);
      neg_ff   <= det_ff[PW];
      // zero-length edges never outline
      span_ff  <= (len2_ff != '0) && !dot_ff[PW] && (dot_ff <= len2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= e_vld;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
      a_lst_ff <= e_lst;
      b_lst_ff <= a_lst_ff;
      c_lst_ff <= b_lst_ff;
      d_lst_ff <= c_lst_ff;
   end

   // accumulate
   logic [CMPW-1:0] lhs, rhs;
   logic            near_hit;
   logic            pos_seen_ff, neg_seen_ff, near_ff, done_ff;

   assign lhs = (CMPW'(pp_hh_ff) << (2 * DW)) + (CMPW'(pp_hl_ff) << (DW + 1))
                + CMPW'(pp_ll_ff);
   assign rhs = CMPW'(rb_ff) << (2 * FRACTION_BITS);
   assign near_hit = span_ff && (lhs <= rhs);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= d_vld_ff && d_lst_ff;
      end
      if (cmd.query_start) begin
         pos_seen_ff <= 1'b0;
         neg_seen_ff <= 1'b0;
         near_ff     <= 1'b0;
      end else if (d_vld_ff) begin
         pos_seen_ff <= pos_seen_ff || pos_ff;
         neg_seen_ff <= neg_seen_ff || neg_ff;
         near_ff     <= near_ff || near_hit;
      end
   end

   // result register
   logic [HEIGHT_W-1:0] h_clamp;
   logic [1:0]          colour;
   logic [1:0]          colour_ff;
   logic [PIXEL_W-1:0]  column_ff, row_ff;
   logic                status_ff;

   assign h_clamp = (height_ff > HEIGHT_W'(MAX_IMAGE_SIZE)) ? HEIGHT_W'(MAX_IMAGE_SIZE)
                                                           : height_ff;

   always_comb begin
      if (count_ff == '0 || (pos_seen_ff && neg_seen_ff)) begin
         colour = COLOUR_NONE;
      end else if (near_ff) begin
         colour = COLOUR_BLACK;
      end else if (fluid_ff) begin
         colour = COLOUR_BLUE;
      end else begin
         colour = COLOUR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_simple) begin
         colour_ff <= COLOUR_NONE;
         column_ff <= '0;
         row_ff    <= '0;
         status_ff <= cmd.append && full;
      end else if (cmd.load_query) begin
         colour_ff <= colour;
         column_ff <= px_ff;
         row_ff    <= PIXEL_W'(h_clamp - HEIGHT_W'(1) - HEIGHT_W'(py_ff));
         status_ff <= 1'b0;
      end
   end

   assign out_colour = colour_ff;
   assign out_column = column_ff;
   assign out_row    = row_ff;
   assign out_status = status_ff;

   assign sts.full    = full;
   assign sts.empty   = (count_ff == '0);
   assign sts.rd_last = rd_last;
   assign sts.done    = done_ff;

   `CPPS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNTW'(MAX_VERTICES))
   `CPPS_ASSERT_NEXT(a_close_after_last, clock, reset, rv_ff && rlast_ff, close_ff)
   `CPPS_ASSERT_NEXT(a_done_from_pipe, clock, reset, d_vld_ff && d_lst_ff, done_ff)

endmodule

>>> rtl/convex_polygon_pixel_shader_top.sv
// top level of the convex polygon pixel shader
// depends on cpps_pkg, cpps_ctrl, cpps_dp and cpps_ram
//
// one convex polygon is held at a time. request transfers carry a function
// code in req_tuser: start empties the polygon and latches the fluid
// flag, append stores one fixed-point vertex unless the store is full,
// query tests one pixel against every closed edge. every request gives
// exactly one response transfer; start, append and unused codes answer in
// the cycle after the transfer. a query reads the stored vertices one per
// cycle from the store memory (its single read port sets the pace), runs
// the edges through an edge-function pipeline and answers once the last
// edge is through it; an empty polygon skips the reads. one request is in flight
// at a time; the next request is taken while the previous response still
// waits in the output register, as long as that register is being drained.
// a stalled receiver holds rsp_tdata steady and, once the result is
// waiting, back-pressures req_tready. reset (synchronous, active high)
// empties the polygon, clears the fluid flag and sets outline width 2 and
// image height 1000; the vertex store itself is not cleared. csr writes take
// effect at once; the user makes them only while the block is idle (unenforced)
module convex_polygon_pixel_shader_top
   import cpps_pkg::*;
#(
   parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // is_fluid[0], vertex_x[16:1], vertex_y[32:17], pixel_x[42:33], pixel_y[52:43]
   input  logic [55:0]           req_tdata,
   // func[1:0]
   input  logic [1:0]            req_tuser,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // colour[1:0], out_column[11:2], out_row[21:12], status[22]
   output logic [23:0]           rsp_tdata,
   // register write port
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type            cmd;
   sts_type            sts;
   logic [1:0]         colour;
   logic [PIXEL_W-1:0] column, row;
   logic               status;

   // sequencing of each request
   cpps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // vertex store, edge pipeline and result register
   cpps_dp #(
      .MAX_VERTICES  (MAX_VERTICES),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_fluid   (req_tdata[0]),
      .in_vx      (req_tdata[16:1]),
      .in_vy      (req_tdata[32:17]),
      .in_px      (req_tdata[42:33]),
      .in_py      (req_tdata[52:43]),
      .cmd        (cmd),
      .sts        (sts),
      .out_colour (colour),
      .out_column (column),
      .out_row    (row),
      .out_status (status)
   );

   // pack the response, zero filled to whole bytes
   assign rsp_tdata = {1'b0, status, row, column, colour};

endmodule
